// ===== design/pbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbs_pkg: shared types and constants for the saturating pixel binner
// Register map codes, field widths, the front/back item flags and the
// saturating add used on the run sum and the line store.
// ----------------------------------------------------------------------------
package pbs_pkg;

   // field widths fixed by the interface
   localparam int PIXEL_W      = 16;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 16;
   localparam int FRAME_W_W    = 13;
   localparam int FRAME_H_W    = 16;
   localparam int BIN_W        = 5;

   // power-on frame geometry
   localparam int RESET_FRAME_WIDTH  = 1024;
   localparam int RESET_FRAME_HEIGHT = 1024;

   // defaults for the top-level parameters
   localparam int DEFAULT_MAX_WIDTH = 4096;
   localparam int DEFAULT_MAX_BIN   = 16;

   // entries in the queue between front and back
   localparam int PBS_QUEUE_DEPTH = 2;

   localparam logic [PIXEL_W-1:0] SAT_MAX = 16'hFFFF;

   // register indexes on the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRAME_WIDTH  = 8'd0,
      REG_FRAME_HEIGHT = 8'd1,
      REG_BIN_X        = 8'd2,
      REG_BIN_Y        = 8'd3
   } pbs_reg_type;

   // classification of one kept pixel, set by the front
   typedef struct packed {
      logic first_col;   // first pixel of a horizontal group
      logic group_end;   // last pixel of a horizontal group
      logic first_row;   // first row of a vertical group
      logic emit;        // block completes here
      logic row_done;
      logic frame_done;
   } pbs_flags_type;

   // 16-bit add that clips at full scale
   function automatic logic [PIXEL_W-1:0] sat_add(input logic [PIXEL_W-1:0] a,
                                                   input logic [PIXEL_W-1:0] b);
      logic [PIXEL_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[PIXEL_W] ? SAT_MAX : sum[PIXEL_W-1:0];
   endfunction

endpackage

// ===== design/pixel_binning_saturating.sv =====
`timescale 1ns / 1ps
// Path: a pixel that completes a block is held in the queue, then the group
//   stage, then the result register, where its binned result can be taken.
// Throughput: one pixel per clock while the output is not stalled; set by the
//   single read and single write of the line store per cycle in the back part.
// Reset: synchronous, active high; geometry returns to 1024x1024 with 1x1 bins,
//   position and queues clear. The line store needs no clearing pass.
// ----------------------------------------------------------------------------
// pixel_binning_saturating: streaming bin_x by bin_y saturating pixel binner
// Front classifies raster pixels and tracks position, a short queue decouples
// it from the back, which sums runs and line-store partials into binned pixels.
// ----------------------------------------------------------------------------
module pixel_binning_saturating import pbs_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
   parameter int MAX_BIN   = DEFAULT_MAX_BIN
) (
   input  logic                   clock,
   input  logic                   reset,
   // pixel input
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_pixel_value,
   // binned output
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIXEL_W-1:0]     rsp_binned_value,
   output logic                   rsp_row_done,
   output logic                   rsp_frame_done,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int FLAG_W = $bits(pbs_flags_type);
   localparam int DATA_W = FLAG_W + AW + PIXEL_W;

   logic               q_push;
   logic [PIXEL_W-1:0] f_pixel;
   logic [AW-1:0]      f_addr;
   pbs_flags_type      f_flags;
   logic               q_pop;
   logic               q_valid;
   logic               q_full;
   logic [DATA_W-1:0]  q_head;
   pbs_flags_type      h_flags;
   logic [AW-1:0]      h_addr;
   logic [PIXEL_W-1:0] h_pixel;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;

   pbs_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BIN   (MAX_BIN)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .q_full          (q_full),
      .req_pixel_value (req_pixel_value),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .push            (q_push),
      .push_pixel      (f_pixel),
      .push_addr       (f_addr),
      .push_flags      (f_flags)
   );

   pbs_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  ({f_flags, f_addr, f_pixel}),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head),
      .full       (q_full)
   );

   assign {h_flags, h_addr, h_pixel} = q_head;

   pbs_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_pixel          (h_pixel),
      .q_addr           (h_addr),
      .q_flags          (h_flags),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_binned_value (rsp_binned_value),
      .rsp_row_done     (rsp_row_done),
      .rsp_frame_done   (rsp_frame_done)
   );

`ifndef SYNTHESIS
   // end of frame is always also the end of a binned row
   a_frame_has_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_frame_done || rsp_row_done))
      else $error("frame_done without row_done");

   // the front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");

   // a pushed beat is visible at the queue head on the next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      q_push |=> q_valid)
      else $error("pushed beat lost");

   // back never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");
`endif

endmodule

// ===== design/pbs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbs_front: frame position tracking and pixel classification
// Holds the geometry registers and the raster position, drops pixels outside
// whole bins and tags each kept pixel with its group position and line address.
// ----------------------------------------------------------------------------
module pbs_front import pbs_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
   parameter int MAX_BIN   = DEFAULT_MAX_BIN
) (
   input  logic                          clock,
   input  logic                          reset,
   // pixel input
   input  logic                          req_valid,
   input  logic                          q_full,
   input  logic [PIXEL_W-1:0]            req_pixel_value,
   // configuration writes
   input  logic                          csr_valid,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   // queue push
   output logic                          push,
   output logic [PIXEL_W-1:0]            push_pixel,
   output logic [$clog2(MAX_WIDTH)-1:0]  push_addr,
   output pbs_flags_type                 push_flags
);

   localparam int CW  = $clog2(MAX_WIDTH + 1);
   localparam int CIW = $clog2(MAX_WIDTH);
   localparam int BW  = $clog2(MAX_BIN + 1);
   localparam int CBW = $clog2(MAX_BIN);
   localparam int FW_RESET = (RESET_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_FRAME_WIDTH;

   // clamped geometry
   logic [CW-1:0]        fw_ff, fw_in;
   logic [FRAME_H_W-1:0] fh_ff, fh_in;
   logic [BW-1:0]        bx_ff, bx_in;
   logic [BW-1:0]        by_ff, by_in;

   // raster position
   logic [CIW-1:0]       ci_ff, ci_in;
   logic [FRAME_H_W-1:0] ri_ff, ri_in;
   logic [CBW-1:0]       cib_ff, cib_in;
   logic [CBW-1:0]       rib_ff, rib_in;
   logic [CIW-1:0]       bc_ff, bc_in;
   logic                 col_ok_ff, col_ok_in;
   logic                 row_ok_ff, row_ok_in;

   logic                 accept;
   logic                 restart;
   logic [CW-1:0]        fw_rem;
   logic [FRAME_H_W-1:0] fh_rem;
   logic                 grp_end;
   logic                 row_last;
   logic                 row_end;
   logic                 frame_end;
   logic                 col_ok;
   logic                 row_ok;
   logic                 rd;

   // bin factor clamp: zero reads as one, large values stop at MAX_BIN
   function automatic logic [BW-1:0] clamp_bin(input logic [BIN_W-1:0] v);
      logic [BW-1:0] r;
      if (v == '0) begin
         r = BW'(1);
      end else if (32'(v) > 32'(MAX_BIN)) begin
         r = BW'(MAX_BIN);
      end else begin
         r = BW'(v);
      end
      return r;
   endfunction

   assign accept = req_valid && !q_full;

   // register decode
   always_comb begin
      fw_in   = fw_ff;
      fh_in   = fh_ff;
      bx_in   = bx_ff;
      by_in   = by_ff;
      restart = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            REG_FRAME_WIDTH: begin
               restart = 1'b1;
               if (csr_wdata[FRAME_W_W-1:0] == '0) begin
                  fw_in = CW'(1);
               end else if (32'(csr_wdata[FRAME_W_W-1:0]) > 32'(MAX_WIDTH)) begin
                  fw_in = CW'(MAX_WIDTH);
               end else begin
                  fw_in = CW'(csr_wdata[FRAME_W_W-1:0]);
               end
            end
            REG_FRAME_HEIGHT: begin
               restart = 1'b1;
               fh_in   = (csr_wdata[FRAME_H_W-1:0] == '0) ? FRAME_H_W'(1)
                                                          : csr_wdata[FRAME_H_W-1:0];
            end
            REG_BIN_X: begin
               restart = 1'b1;
               bx_in   = clamp_bin(csr_wdata[BIN_W-1:0]);
            end
            REG_BIN_Y: begin
               restart = 1'b1;
               by_in   = clamp_bin(csr_wdata[BIN_W-1:0]);
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   // classification: whole-group checks are made at group starts and held
   always_comb begin
      fw_rem    = fw_ff - CW'(ci_ff);
      fh_rem    = fh_ff - ri_ff;
      col_ok    = (cib_ff == '0) ? (32'(fw_rem) >= 32'(bx_ff)) : col_ok_ff;
      row_ok    = (rib_ff == '0) ? (32'(fh_rem) >= 32'(by_ff)) : row_ok_ff;
      grp_end   = (32'(cib_ff) + 32'd1) >= 32'(bx_ff);
      row_last  = (32'(rib_ff) + 32'd1) >= 32'(by_ff);
      row_end   = (32'(ci_ff) + 32'd1) >= 32'(fw_ff);
      frame_end = (32'(ri_ff) + 32'd1) >= 32'(fh_ff);
      rd        = 32'(fw_rem) <= 32'(bx_ff);
      col_ok_in = col_ok;
      row_ok_in = row_ok;

      push                  = accept && col_ok && row_ok;
      push_pixel            = req_pixel_value;
      push_addr             = bc_ff;
      push_flags.first_col  = (cib_ff == '0);
      push_flags.group_end  = grp_end;
      push_flags.first_row  = (rib_ff == '0);
      push_flags.emit       = grp_end && row_last;
      push_flags.row_done   = rd;
      push_flags.frame_done = rd && (32'(fh_rem) <= 32'(by_ff));
   end

   // position advance
   always_comb begin
      cib_in = grp_end ? '0 : cib_ff + CBW'(1);
      rib_in = rib_ff;
      ri_in  = ri_ff;
      if (row_end) begin
         ci_in  = '0;
         cib_in = '0;
         bc_in  = '0;
         rib_in = row_last ? '0 : rib_ff + CBW'(1);
         if (frame_end) begin
            ri_in  = '0;
            rib_in = '0;
         end else begin
            ri_in = ri_ff + FRAME_H_W'(1);
         end
      end else begin
         ci_in = ci_ff + CIW'(1);
         bc_in = grp_end ? bc_ff + CIW'(1) : bc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff     <= CW'(FW_RESET);
         fh_ff     <= FRAME_H_W'(RESET_FRAME_HEIGHT);
         bx_ff     <= BW'(1);
         by_ff     <= BW'(1);
         ci_ff     <= '0;
         ri_ff     <= '0;
         cib_ff    <= '0;
         rib_ff    <= '0;
         bc_ff     <= '0;
         col_ok_ff <= 1'b0;
         row_ok_ff <= 1'b0;
      end else if (restart) begin
         fw_ff  <= fw_in;
         fh_ff  <= fh_in;
         bx_ff  <= bx_in;
         by_ff  <= by_in;
         ci_ff  <= '0;
         ri_ff  <= '0;
         cib_ff <= '0;
         rib_ff <= '0;
         bc_ff  <= '0;
      end else if (accept) begin
         ci_ff     <= ci_in;
         ri_ff     <= ri_in;
         cib_ff    <= cib_in;
         rib_ff    <= rib_in;
         bc_ff     <= bc_in;
         col_ok_ff <= col_ok_in;
         row_ok_ff <= row_ok_in;
      end
   end

endmodule

// ===== design/pbs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbs_queue: short queue between front and back
// Small circular buffer; full is a registered count so the input stall does
// not depend on the back side in the same cycle.
// ----------------------------------------------------------------------------
module pbs_queue import pbs_pkg::*; #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              head_valid,
   output logic [DATA_W-1:0] head_data,
   output logic              full
);

   localparam int PW   = (PBS_QUEUE_DEPTH > 1) ? $clog2(PBS_QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(PBS_QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] entries_ff [PBS_QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]   count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNTW'(PBS_QUEUE_DEPTH));
   assign head_data  = entries_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(PBS_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(PBS_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/pbs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbs_back: run sum, line store and result register
// Pops classified pixels, keeps the horizontal run sum, reads the line store
// for each finished group, then writes the partial sum back or emits the bin.
// ----------------------------------------------------------------------------
module pbs_back import pbs_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   // queue head
   input  logic                          q_valid,
   input  logic [PIXEL_W-1:0]            q_pixel,
   input  logic [$clog2(MAX_WIDTH)-1:0]  q_addr,
   input  pbs_flags_type                 q_flags,
   output logic                          pop,
   // results
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [PIXEL_W-1:0]            rsp_binned_value,
   output logic                          rsp_row_done,
   output logic                          rsp_frame_done
);

   localparam int AW = $clog2(MAX_WIDTH);

   // line store of partial vertical sums
   logic [PIXEL_W-1:0] line_mem [MAX_WIDTH];
   logic [PIXEL_W-1:0] rdata_ff;

   logic [PIXEL_W-1:0] run_ff, run_in;

   // group stage
   logic               b_valid_ff, b_valid_in;
   logic [PIXEL_W-1:0] b_run_ff;
   logic [AW-1:0]      b_addr_ff;
   pbs_flags_type      b_flags_ff;
   logic               fwd_ff, fwd_in;
   logic [PIXEL_W-1:0] fwd_data_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_value_ff;
   logic               rsp_rd_ff;
   logic               rsp_fd_ff;

   logic               out_free;
   logic               b_fire;
   logic               b_write;
   logic               load_b;
   logic [PIXEL_W-1:0] line_val;
   logic [PIXEL_W-1:0] partial;

   // stage handshakes
   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      b_fire     = b_valid_ff && (!b_flags_ff.emit || out_free);
      b_write    = b_fire && !b_flags_ff.emit;
      pop        = q_valid && (!b_valid_ff || b_fire);
      load_b     = pop && q_flags.group_end;
      b_valid_in = load_b ? 1'b1 : (b_fire ? 1'b0 : b_valid_ff);
      run_in     = q_flags.first_col ? q_pixel : sat_add(run_ff, q_pixel);
      // a write landing on the address being read this cycle is forwarded
      fwd_in     = b_write && (b_addr_ff == q_addr);
   end

   // vertical accumulate
   always_comb begin
      line_val = fwd_ff ? fwd_data_ff : rdata_ff;
      partial  = b_flags_ff.first_row ? b_run_ff : sat_add(line_val, b_run_ff);
   end

   // result valid
   always_comb begin
      if (b_fire && b_flags_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         run_ff <= run_in;
      end
      if (load_b) begin
         b_run_ff    <= run_in;
         b_addr_ff   <= q_addr;
         b_flags_ff  <= q_flags;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= partial;
      end
      if (b_fire && b_flags_ff.emit) begin
         rsp_value_ff <= partial;
         rsp_rd_ff    <= b_flags_ff.row_done;
         rsp_fd_ff    <= b_flags_ff.frame_done;
      end
   end

   // line store: one read and one write port
   always_ff @(posedge clock) begin
      if (load_b) begin
         rdata_ff <= line_mem[q_addr];
      end
      if (b_write) begin
         line_mem[b_addr_ff] <= partial;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_binned_value = rsp_value_ff;
   assign rsp_row_done     = rsp_rd_ff;
   assign rsp_frame_done   = rsp_fd_ff;

endmodule
